/* src/rfs_pkg.sv */
// Shared types and constants for the Q31 real FFT split stage.
package rfs_pkg;

    localparam int MAX_HALF_LEN    = 2048;
    localparam int TWIDDLE_ENTRIES = 4096;
    localparam int PT_DEPTH        = MAX_HALF_LEN + 1;
    localparam int PT_AW           = $clog2(PT_DEPTH);
    localparam int TW_AW           = $clog2(TWIDDLE_ENTRIES);

    localparam int IDX_W      = 12;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int HLEN_W     = 12;
    localparam int STRIDE_W   = 13;
    localparam int TADDR_W    = IDX_W + STRIDE_W;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [FUNC_W-1:0] FUNC_WR_POINT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_TWIDDLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RD_BIN     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE      = 2'd2;

    localparam logic [HLEN_W-1:0]   HLEN_RESET   = HLEN_W'(2048);
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [IDX_W-1:0]         index;
        logic signed [WORD_W-1:0] first_word;
        logic signed [WORD_W-1:0] second_word;
        logic signed [WORD_W-1:0] third_word;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         bin_index;
        logic signed [WORD_W-1:0] out_re;
        logic signed [WORD_W-1:0] out_im;
        logic                     error;
    } t_out_item;

endpackage

/* src/rfs_in_if.sv */
// Valid/ready channel carrying input items of the split stage.
interface rfs_in_if;
    logic              valid;
    logic              ready;
    rfs_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/rfs_out_if.sv */
// Valid/ready channel carrying result items of the split stage.
interface rfs_out_if;
    logic               valid;
    logic               ready;
    rfs_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/real_fft_split_stage_q31.sv */
// Q31 real FFT split stage: point and twiddle stores plus one-bin-at-a-time evaluator.
// Items are taken only in idle, where writes land. A bin read steps S_ADDR (store read),
// S_MRE/S_MIM (products), S_SRE/S_SIM (round and sum) and S_OUT; DC/Nyquist bins skip from
// S_MRE and error bins from S_ADDR to S_OUT, which waits for a free output register.
// Reset: direction 0, half_length 2048, stride 1, FSM idle, output empty;
// the stores are not cleared and hold whatever was last written.
module real_fft_split_stage_q31 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rfs_in_if.sink                            i_in,
    rfs_out_if.source                         o_out
);

    // Sign patterns for the four products (bit i negates product i).
    // Re products: a*A1, b*A2, c*A2, d*B1.  Im products: a*A2, b*A1, c*B1, d*A2.
    localparam logic [3:0] NEG_FWD_RE = 4'b0110;
    localparam logic [3:0] NEG_INV_RE = 4'b0000;
    localparam logic [3:0] NEG_FWD_IM = 4'b1100;
    localparam logic [3:0] NEG_INV_IM = 4'b0100;  // bit 0 set per A2 below

    localparam logic [rfs_pkg::WORD_W-1:0] WORD_MIN = {1'b1, {(rfs_pkg::WORD_W-1){1'b0}}};
    localparam logic [rfs_pkg::PROD_W-1:0] RND_BIAS = rfs_pkg::PROD_W'(WORD_MIN);

    typedef enum logic [2:0] {
        S_IDLE,  // take transfers; writes land in the stores here
        S_ADDR,  // form bin addresses, check ranges, issue store reads
        S_MRE,   // real-part products (or DC/Nyquist sum)
        S_MIM,   // imaginary-part products, round real products
        S_SRE,   // sum real part, round imaginary products
        S_SIM,   // sum imaginary part, conjugate for mirrored bins
        S_OUT    // load output register once it is free
    } t_state;

    t_state r_state;

    // configuration
    logic                            r_dir;
    logic [rfs_pkg::HLEN_W-1:0]      r_hlen;
    logic [rfs_pkg::STRIDE_W-1:0]    r_stride;

    // captured request
    logic [rfs_pkg::IDX_W-1:0]       r_idx;
    logic                            r_err;
    logic                            r_spec;
    logic                            r_diff;
    logic                            r_conj;

    // stores: point = {im, re}, twiddle A = {odd, even}, twiddle B = even word
    logic [rfs_pkg::PROD_W-1:0]      mem_pt [rfs_pkg::PT_DEPTH];
    logic [rfs_pkg::PROD_W-1:0]      mem_ta [rfs_pkg::TWIDDLE_ENTRIES];
    logic [rfs_pkg::WORD_W-1:0]      mem_tb [rfs_pkg::TWIDDLE_ENTRIES];

    logic [rfs_pkg::PROD_W-1:0]      r_pa;
    logic [rfs_pkg::PROD_W-1:0]      r_pb;
    logic [rfs_pkg::PROD_W-1:0]      r_ta;
    logic [rfs_pkg::WORD_W-1:0]      r_tb;

    logic signed [rfs_pkg::PROD_W-1:0] r_prod [4];
    logic [3:0]                        r_neg;
    logic [rfs_pkg::WORD_W-1:0]        r_rnd  [4];
    logic [rfs_pkg::WORD_W-1:0]        r_sum_re;
    logic [rfs_pkg::WORD_W-1:0]        r_sum_im;

    logic                            r_out_valid;
    rfs_pkg::t_out_item              r_out;

    // handshake
    logic in_xfer;
    logic out_free;
    logic pt_we;
    logic tw_we;
    logic rd_en;

    // address stage
    logic                            idx_lt_n;
    logic [rfs_pkg::HLEN_W:0]        two_n;
    logic [rfs_pkg::IDX_W-1:0]       k;
    logic [rfs_pkg::IDX_W-1:0]       nk;
    logic [rfs_pkg::TADDR_W-1:0]     t;
    logic                            spec;
    logic                            bad_len;
    logic                            bin_err;
    logic                            tw_err;
    logic                            addr_err;
    logic [rfs_pkg::PT_AW-1:0]       pa_addr;
    logic [rfs_pkg::PT_AW-1:0]       pb_addr;
    logic [rfs_pkg::TW_AW-1:0]       tw_addr;

    // operands
    logic signed [rfs_pkg::WORD_W-1:0] op_a, op_b, op_c, op_d, op_a1, op_a2, op_b1;
    logic signed [rfs_pkg::WORD_W:0]   dc_sum;
    logic [rfs_pkg::WORD_W-1:0]        sum4;

    function automatic logic signed [rfs_pkg::PROD_W-1:0] mul(
        input logic signed [rfs_pkg::WORD_W-1:0] x,
        input logic signed [rfs_pkg::WORD_W-1:0] y
    );
        return x * y;
    endfunction

    // (+/-p + 2^31) >> 32, keeping 32 wrapping bits
    function automatic logic [rfs_pkg::WORD_W-1:0] rnd(
        input logic signed [rfs_pkg::PROD_W-1:0] p,
        input logic                              neg
    );
        logic [rfs_pkg::PROD_W-1:0] v;
        logic [rfs_pkg::PROD_W-1:0] s;
        v = neg ? (~p + rfs_pkg::PROD_W'(1)) : p;
        s = v + RND_BIAS;
        return s[rfs_pkg::PROD_W-1:rfs_pkg::WORD_W];
    endfunction

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign pt_we    = in_xfer && (i_in.data.func == rfs_pkg::FUNC_WR_POINT)
                   && (32'(i_in.data.index) <= rfs_pkg::MAX_HALF_LEN);
    assign tw_we    = in_xfer && (i_in.data.func == rfs_pkg::FUNC_WR_TWIDDLE)
                   && (32'(i_in.data.index) < rfs_pkg::TWIDDLE_ENTRIES);
    assign rd_en    = (r_state == S_ADDR);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Bin k and its partner N-k; mirrored forward bins fold back onto 2N-idx.
    always_comb begin
        idx_lt_n = r_idx < r_hlen;
        two_n    = {r_hlen, 1'b0};
        k        = idx_lt_n ? r_idx : rfs_pkg::IDX_W'(two_n - {1'b0, r_idx});
        nk       = r_hlen - k;
        t        = rfs_pkg::TADDR_W'(k) * rfs_pkg::TADDR_W'(r_stride);
        spec     = !r_dir && ((r_idx == '0) || (r_idx == r_hlen));
        bad_len  = (r_hlen == '0) || (32'(r_hlen) > rfs_pkg::MAX_HALF_LEN);
        bin_err  = r_dir ? !idx_lt_n : ({1'b0, r_idx} >= two_n);
        tw_err   = !spec && (32'(t) >= rfs_pkg::TWIDDLE_ENTRIES);
        addr_err = bad_len || bin_err || tw_err;
        // DC and Nyquist both need point 0 only
        pa_addr  = spec ? '0 : rfs_pkg::PT_AW'(k);
        pb_addr  = rfs_pkg::PT_AW'(nk);
        tw_addr  = t[rfs_pkg::TW_AW-1:0];
    end

    assign op_a  = r_pa[rfs_pkg::WORD_W-1:0];
    assign op_b  = r_pa[rfs_pkg::PROD_W-1:rfs_pkg::WORD_W];
    assign op_d  = r_pb[rfs_pkg::WORD_W-1:0];
    assign op_c  = r_pb[rfs_pkg::PROD_W-1:rfs_pkg::WORD_W];
    assign op_a1 = r_ta[rfs_pkg::WORD_W-1:0];
    assign op_a2 = r_ta[rfs_pkg::PROD_W-1:rfs_pkg::WORD_W];
    assign op_b1 = r_tb;

    assign dc_sum = r_diff ? ({op_a[rfs_pkg::WORD_W-1], op_a} - {op_b[rfs_pkg::WORD_W-1], op_b})
                           : ({op_a[rfs_pkg::WORD_W-1], op_a} + {op_b[rfs_pkg::WORD_W-1], op_b});
    assign sum4   = r_rnd[0] + r_rnd[1] + r_rnd[2] + r_rnd[3];

    // Stores. Writes happen only in idle and reads only after, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            mem_pt[rfs_pkg::PT_AW'(i_in.data.index)] <=
                {i_in.data.second_word, i_in.data.first_word};
        end
        if (rd_en) begin
            r_pa <= mem_pt[pa_addr];
            r_pb <= mem_pt[pb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tw_we) begin
            mem_ta[rfs_pkg::TW_AW'(i_in.data.index)] <=
                {i_in.data.second_word, i_in.data.first_word};
            mem_tb[rfs_pkg::TW_AW'(i_in.data.index)] <= i_in.data.third_word;
        end
        if (rd_en) begin
            r_ta <= mem_ta[tw_addr];
            r_tb <= mem_tb[tw_addr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= 1'b0;
            r_hlen   <= rfs_pkg::HLEN_RESET;
            r_stride <= rfs_pkg::STRIDE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rfs_pkg::CFG_DIRECTION:   r_dir    <= i_cfg_data[0];
                rfs_pkg::CFG_HALF_LENGTH: r_hlen   <= i_cfg_data[rfs_pkg::HLEN_W-1:0];
                rfs_pkg::CFG_STRIDE:      r_stride <= i_cfg_data[rfs_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // arithmetic pipeline, stepped by the FSM
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MRE: begin
                if (r_spec) begin
                    r_sum_re <= dc_sum[rfs_pkg::WORD_W:1];
                    r_sum_im <= '0;
                end
                r_prod[0] <= mul(op_a, op_a1);
                r_prod[1] <= mul(op_b, op_a2);
                r_prod[2] <= mul(op_c, op_a2);
                r_prod[3] <= mul(op_d, op_b1);
                r_neg     <= r_dir ? NEG_INV_RE : NEG_FWD_RE;
            end
            S_MIM: begin
                for (int i = 0; i < 4; i++) r_rnd[i] <= rnd(r_prod[i], r_neg[i]);
                r_prod[0] <= mul(op_a, op_a2);
                r_prod[1] <= mul(op_b, op_a1);
                r_prod[2] <= mul(op_c, op_b1);
                r_prod[3] <= mul(op_d, op_a2);
                // inverse: a * (-A2), where -A2 wraps to A2 at the most negative word
                r_neg     <= r_dir ? (NEG_INV_IM | {3'b000, op_a2 != WORD_MIN}) : NEG_FWD_IM;
            end
            S_SRE: begin
                r_sum_re <= sum4;
                for (int i = 0; i < 4; i++) r_rnd[i] <= rnd(r_prod[i], r_neg[i]);
            end
            S_SIM: begin
                r_sum_im <= r_conj ? (rfs_pkg::WORD_W'(0) - sum4) : sum4;
            end
            default: ;
        endcase
    end

    // control FSM and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_err       <= 1'b0;
            r_spec      <= 1'b0;
            r_diff      <= 1'b0;
            r_conj      <= 1'b0;
        end else begin
            // in the output stage the load below decides the valid flag
            if (r_out_valid && o_out.ready && (r_state != S_OUT)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in.data.func == rfs_pkg::FUNC_RD_BIN)) begin
                        r_idx   <= i_in.data.index;
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_err   <= addr_err;
                    r_spec  <= spec;
                    r_diff  <= (r_idx != '0);
                    r_conj  <= !r_dir && !idx_lt_n;
                    r_state <= addr_err ? S_OUT : S_MRE;
                end
                S_MRE:   r_state <= r_spec ? S_OUT : S_MIM;
                S_MIM:   r_state <= S_SRE;
                S_SRE:   r_state <= S_SIM;
                S_SIM:   r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_out.bin_index <= r_idx;
                        r_out.out_re    <= r_err ? '0 : r_sum_re;
                        r_out.out_im    <= r_err ? '0 : r_sum_im;
                        r_out.error     <= r_err;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in.data.func == rfs_pkg::FUNC_RD_BIN) |=> r_state == S_ADDR)
        else $error("read transfer did not start address stage");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result appeared outside the output stage");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.error |-> (r_out.out_re == '0) && (r_out.out_im == '0))
        else $error("error result carries nonzero data");

    a_mul_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MIM |-> $past(r_state) == S_MRE && !r_spec && !r_err)
        else $error("product sequence entered on special or error bin");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !out_free |=> r_state == S_OUT && r_out_valid)
        else $error("output stage left while output register was occupied");

endmodule
